FILE: rtl/core/fcc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
`timescale 1ns / 1ps

package fcc_pkg;

   // Frame parser phases
   typedef enum logic [1:0] {
      PH_PROTO   = 2'd0,
      PH_LEN     = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CRC     = 2'd3
   } phase_type;

   // Result status codes
   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_BAD_PROTO = 2'd1;
   localparam logic [1:0] ST_BAD_CRC   = 2'd2;
   localparam logic [1:0] ST_TOO_LONG  = 2'd3;

   localparam logic [7:0]  PROTO_A  = 8'hA1;
   localparam logic [7:0]  PROTO_B  = 8'h1A;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam int unsigned CRC_FIELD_BYTES = 4;
   localparam int unsigned CRC_CNT_W = 2;

   // One received word as it travels from the input register to the parser
   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } item_type;

   // Reflected CRC-32 over one byte, LSB first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = CRC_POLY ^ (c >> 1);
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/fcc_in_reg.sv
// Input register stage: holds one word until the parser takes it.
`timescale 1ns / 1ps

module fcc_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fcc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output fcc_pkg::item_type out_item
);

   logic              valid_ff;
   fcc_pkg::item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

FILE: rtl/core/fcc_parser.sv
// Frame parser: phase tracking, running CRC, length check and result register.
`timescale 1ns / 1ps

module fcc_parser #(
   parameter int unsigned LENGTH_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       max_len,
   input  logic              in_valid,
   output logic              in_ready,
   input  fcc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [1:0]        out_status,
   output logic [31:0]       out_length,
   output logic [31:0]       out_crc
);

   localparam int unsigned HdrW = $clog2(LENGTH_BYTES + 1);

   fcc_pkg::phase_type   phase_ff, phase_in;
   logic [HdrW-1:0]      hdr_cnt_ff, hdr_cnt_in, hdr_cnt_inc;
   logic [31:0]          pay_cnt_ff, pay_cnt_in, pay_cnt_inc;
   logic [fcc_pkg::CRC_CNT_W-1:0] crc_cnt_ff, crc_cnt_in;
   logic [31:0]          len_ff, len_in, len_shift;
   logic [31:0]          crc_ff, crc_in, crc_upd;
   logic [31:0]          rx_crc_ff, rx_crc_in, rx_shift;
   logic                 good_ff, good_in;
   fcc_pkg::phase_type   phase_eff;
   logic [31:0]          crc_base;
   logic                 take;
   logic                 emit;
   logic [1:0]           st;
   logic [31:0]          res_len, res_crc;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [31:0]          rsp_len_ff, rsp_crc_ff;

   assign in_ready   = !rsp_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = rsp_valid_ff;
   assign out_status = rsp_status_ff;
   assign out_length = rsp_len_ff;
   assign out_crc    = rsp_crc_ff;

   assign phase_eff   = in_item.restart ? fcc_pkg::PH_PROTO : phase_ff;
   assign crc_base    = (phase_eff == fcc_pkg::PH_PROTO) ? fcc_pkg::CRC_INIT : crc_ff;
   assign crc_upd     = fcc_pkg::crc32_byte(crc_base, in_item.data_byte);
   assign len_shift   = {len_ff[23:0], in_item.data_byte};
   assign rx_shift    = {rx_crc_ff[23:0], in_item.data_byte};
   assign hdr_cnt_inc = hdr_cnt_ff + 1'b1;
   assign pay_cnt_inc = pay_cnt_ff + 32'd1;

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      pay_cnt_in = pay_cnt_ff;
      crc_cnt_in = crc_cnt_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      rx_crc_in  = rx_crc_ff;
      good_in    = good_ff;
      emit       = 1'b0;
      st         = fcc_pkg::ST_VALID;
      res_len    = len_ff;
      res_crc    = crc_ff;
      case (phase_eff)
         fcc_pkg::PH_PROTO: begin
            good_in    = (in_item.data_byte == fcc_pkg::PROTO_A) ||
                         (in_item.data_byte == fcc_pkg::PROTO_B);
            crc_in     = crc_upd;
            len_in     = 32'd0;
            rx_crc_in  = 32'd0;
            hdr_cnt_in = '0;
            pay_cnt_in = 32'd0;
            crc_cnt_in = '0;
            phase_in   = fcc_pkg::PH_LEN;
         end
         fcc_pkg::PH_LEN: begin
            crc_in = crc_upd;
            len_in = len_shift;
            if (hdr_cnt_inc >= HdrW'(LENGTH_BYTES)) begin
               hdr_cnt_in = '0;
               if (len_shift > max_len) begin
                  emit      = 1'b1;
                  st        = fcc_pkg::ST_TOO_LONG;
                  res_len   = len_shift;
                  res_crc   = crc_upd;
                  phase_in  = fcc_pkg::PH_PROTO;
                  len_in    = 32'd0;
                  crc_in    = fcc_pkg::CRC_INIT;
                  rx_crc_in = 32'd0;
                  good_in   = 1'b0;
               end else if (len_shift == 32'd0) begin
                  phase_in = fcc_pkg::PH_CRC;
               end else begin
                  phase_in = fcc_pkg::PH_PAYLOAD;
               end
            end else begin
               hdr_cnt_in = hdr_cnt_inc;
            end
         end
         fcc_pkg::PH_PAYLOAD: begin
            crc_in = crc_upd;
            if (pay_cnt_inc >= len_ff) begin
               pay_cnt_in = 32'd0;
               phase_in   = fcc_pkg::PH_CRC;
            end else begin
               pay_cnt_in = pay_cnt_inc;
            end
         end
         fcc_pkg::PH_CRC: begin
            rx_crc_in = rx_shift;
            if (crc_cnt_ff == fcc_pkg::CRC_CNT_W'(fcc_pkg::CRC_FIELD_BYTES - 1)) begin
               emit = 1'b1;
               if (!good_ff) begin
                  st = fcc_pkg::ST_BAD_PROTO;
               end else if (rx_shift != crc_ff) begin
                  st = fcc_pkg::ST_BAD_CRC;
               end else begin
                  st = fcc_pkg::ST_VALID;
               end
               crc_cnt_in = '0;
               phase_in   = fcc_pkg::PH_PROTO;
               len_in     = 32'd0;
               crc_in     = fcc_pkg::CRC_INIT;
               rx_crc_in  = 32'd0;
               good_in    = 1'b0;
            end else begin
               crc_cnt_in = crc_cnt_ff + 1'b1;
            end
         end
         default: begin
            phase_in = fcc_pkg::PH_PROTO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= fcc_pkg::PH_PROTO;
         hdr_cnt_ff <= '0;
         pay_cnt_ff <= 32'd0;
         crc_cnt_ff <= '0;
         len_ff     <= 32'd0;
         crc_ff     <= fcc_pkg::CRC_INIT;
         rx_crc_ff  <= 32'd0;
         good_ff    <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         pay_cnt_ff <= pay_cnt_in;
         crc_cnt_ff <= crc_cnt_in;
         len_ff     <= len_in;
         crc_ff     <= crc_in;
         rx_crc_ff  <= rx_crc_in;
         good_ff    <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= emit;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_status_ff <= st;
         rsp_len_ff    <= res_len;
         rsp_crc_ff    <= res_crc;
      end
   end

endmodule

FILE: rtl/core/crc32_frame_checker.sv
// Top level of the length-prefixed frame checker with running CRC-32.
`timescale 1ns / 1ps

//  channel   direction  handshake               payload
//  req_      in         req_valid / req_ready   req_data_byte[7:0], req_restart
//  rsp_      out        rsp_valid / rsp_ready   rsp_status[1:0], rsp_payload_length[31:0],
//                                               rsp_computed_crc[31:0]
//  csr_      in         csr_valid / csr_ready   csr_data[31:0] (max payload length)
//
//  One word a cycle sustained while rsp_ is not stalled; the parser takes the word held in
//  the input register, and its status word (if any) is valid from that same edge.
//  The byte-wide CRC update and the 32-bit length compare set the path per word.
//  Reset is synchronous: it clears the frame state, empties both stages and sets
//  the length limit to 4096. A stalled rsp_ holds the result register and, once the
//  input register is full, req_ready drops; csr_ is always ready.

module crc32_frame_checker #(
   parameter int unsigned LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_payload_length,
   output logic [31:0] rsp_computed_crc,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam logic [31:0] MaxLenReset = 32'd4096;

   logic [31:0]       max_len_ff;
   fcc_pkg::item_type req_item;
   fcc_pkg::item_type stage_item;
   logic              stage_valid;
   logic              stage_ready;

   // Length limit register: written whenever the port offers a word
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   assign req_item.data_byte = req_data_byte;
   assign req_item.restart   = req_restart;

   // Hold the incoming word until the parser is free to advance
   fcc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   // Advance the frame state and load the status word at the end of a frame
   fcc_parser #(
      .LENGTH_BYTES (LENGTH_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .max_len    (max_len_ff),
      .in_valid   (stage_valid),
      .in_ready   (stage_ready),
      .in_item    (stage_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_status (rsp_status),
      .out_length (rsp_payload_length),
      .out_crc    (rsp_computed_crc)
   );

endmodule

FILE: sim/tb.sv
// Self-checking bench for the CRC-32 frame checker: scripted opening, then random frames.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned LEN_FIELD   = 4;    // length bytes in each frame header
   localparam int unsigned PHASE_WORDS = 250;  // random words per limit setting
   localparam int unsigned SCRIPT_ROWS = 26;

   // One status word as the result channel carries it
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] length;
      logic [31:0] crc;
   } status_word_type;

   // One scripted input word; a pinned row carries its status word typed in
   typedef struct packed {
      logic [7:0]  value;
      logic        restart;
      logic        opens;     // first word of a frame: reseed the running CRC
      logic        crc_byte;  // send byte value[1:0] of the good CRC instead of value
      logic        pinned;
      logic [1:0]  status;
      logic [31:0] length;
   } script_row_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   wire         req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_restart   = 1'b0;
   wire         rsp_valid;
   logic        rsp_ready     = 1'b0;
   wire  [1:0]  rsp_status;
   wire  [31:0] rsp_payload_length;
   wire  [31:0] rsp_computed_crc;
   logic        csr_valid     = 1'b0;
   wire         csr_ready;
   logic [31:0] csr_data      = 32'h0;

   // Typed-in expectation travelling with the word it belongs to
   logic        pin_on     = 1'b0;
   logic [1:0]  pin_status = fcc_pkg::ST_VALID;
   logic [31:0] pin_length = 32'h0;

   int          faults     = 0;
   int          words_sent = 0;
   bit          idling     = 1'b1;
   bit          resync     = 1'b0;
   logic [31:0] cur_limit  = 32'd4096;

   status_word_type awaited[$];

   // Parser mirror: phase, counters and CRC of the frame in flight
   fcc_pkg::phase_type prs_phase;
   logic [31:0] prs_count;
   logic [31:0] prs_length;
   logic [31:0] prs_crc;
   logic [31:0] prs_rx_crc;
   logic [31:0] prs_limit;
   logic        prs_proto_ok;

   script_row_type script [0:SCRIPT_ROWS-1] = '{
      // bad protocol byte with an all-ones length: the length report wins
      '{8'h00,    0, 1, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'hFF,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'hFF,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'hFF,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'hFF,    0, 0, 0, 1, fcc_pkg::ST_TOO_LONG,  32'hFFFF_FFFF},
      // empty payload, bad protocol byte and a wrong CRC: protocol error wins
      '{8'h55,    0, 1, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 1, fcc_pkg::ST_BAD_PROTO, 32'h0},
      // partial frame, dropped by the restart that follows
      '{fcc_pkg::PROTO_A, 0, 1, 0, 0, fcc_pkg::ST_VALID, 32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      // clean one-byte frame opened by restart
      '{fcc_pkg::PROTO_B, 1, 1, 0, 0, fcc_pkg::ST_VALID, 32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h01,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'hFF,    0, 0, 0, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h00,    0, 0, 1, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h01,    0, 0, 1, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h02,    0, 0, 1, 0, fcc_pkg::ST_VALID,     32'h0},
      '{8'h03,    0, 0, 1, 1, fcc_pkg::ST_VALID,     32'd1}
   };

   crc32_frame_checker #(
      .LENGTH_BYTES(LEN_FIELD)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_length (rsp_payload_length),
      .rsp_computed_crc   (rsp_computed_crc),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Reflected CRC-32, one data bit folded in per shift
   function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) begin
            r = (r >> 1) ^ fcc_pkg::CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   task automatic clear_frame();
      prs_phase    = fcc_pkg::PH_PROTO;
      prs_count    = '0;
      prs_length   = '0;
      prs_crc      = fcc_pkg::CRC_INIT;
      prs_rx_crc   = '0;
      prs_proto_ok = 1'b0;
   endtask

   // Queue the status word of the frame in flight; a pinned row overrides status and length
   task automatic post_status(input logic [1:0] st);
      status_word_type w;
      w.status = st;
      w.length = prs_length;
      w.crc    = prs_crc;
      if (pin_on) begin
         w.status = pin_status;
         w.length = pin_length;
      end
      awaited.push_back(w);
   endtask

   // Advance the parser mirror by one accepted word
   task automatic parse_word(input logic [7:0] b, input logic r);
      logic [1:0] st;
      if (r) clear_frame();
      case (prs_phase)
         fcc_pkg::PH_PROTO: begin
            clear_frame();
            prs_proto_ok = (b == fcc_pkg::PROTO_A) || (b == fcc_pkg::PROTO_B);
            prs_crc      = crc_next(prs_crc, b);
            prs_phase    = fcc_pkg::PH_LEN;
         end
         fcc_pkg::PH_LEN: begin
            prs_crc    = crc_next(prs_crc, b);
            prs_length = {prs_length[23:0], b};
            prs_count++;
            if (prs_count >= LEN_FIELD) begin
               prs_count = '0;
               // over-long header: report at once and hunt for a new frame
               if (prs_length > prs_limit) begin
                  post_status(fcc_pkg::ST_TOO_LONG);
                  clear_frame();
               end else if (prs_length == 0) begin
                  prs_phase = fcc_pkg::PH_CRC;
               end else begin
                  prs_phase = fcc_pkg::PH_PAYLOAD;
               end
            end
         end
         fcc_pkg::PH_PAYLOAD: begin
            prs_crc = crc_next(prs_crc, b);
            prs_count++;
            if (prs_count >= prs_length) begin
               prs_count = '0;
               prs_phase = fcc_pkg::PH_CRC;
            end
         end
         default: begin
            prs_rx_crc = {prs_rx_crc[23:0], b};
            prs_count++;
            if (prs_count >= fcc_pkg::CRC_FIELD_BYTES) begin
               // a bad protocol byte outranks a CRC mismatch
               if (!prs_proto_ok) begin
                  st = fcc_pkg::ST_BAD_PROTO;
               end else if (prs_rx_crc != prs_crc) begin
                  st = fcc_pkg::ST_BAD_CRC;
               end else begin
                  st = fcc_pkg::ST_VALID;
               end
               post_status(st);
               clear_frame();
            end
         end
      endcase
   endtask

   // Compare one delivered status word with the oldest one awaited
   task automatic check_word();
      status_word_type want;
      if (awaited.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("unexpected status word: st=%0d len=%h crc=%h",
                     rsp_status, rsp_payload_length, rsp_computed_crc);
      end else begin
         want = awaited.pop_front();
         if (want.status !== rsp_status || want.length !== rsp_payload_length ||
             want.crc !== rsp_computed_crc) begin
            faults++;
            if (faults <= 10)
               $display({"status word mismatch: want st=%0d len=%h crc=%h,",
                         " got st=%0d len=%h crc=%h"},
                        want.status, want.length, want.crc,
                        rsp_status, rsp_payload_length, rsp_computed_crc);
         end
      end
   endtask

   // Sample all three channels on the edge, before any of this step's drives land
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         prs_limit = 32'd4096;
         awaited.delete();
      end else begin
         if (csr_valid && csr_ready) prs_limit = csr_data;
         if (rsp_valid && rsp_ready) check_word();
         if (req_valid && req_ready) parse_word(req_data_byte, req_restart);
      end
   end

   // Stall the result channel about one cycle in eight while idling is on
   always @(posedge clock) begin
      rsp_ready <= !idling || ($urandom_range(0, 99) >= 12);
   end

   // Offer one word, after a random gap, and hold it until taken
   task automatic send_word(input logic [7:0] b, input logic r);
      int gap;
      gap = 0;
      while (idling && $urandom_range(0, 99) < 12) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_restart   <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
   endtask

   // Hold the sender until every status word is in, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      cur_limit = v;
   endtask

   // One random frame: mostly well formed, some corrupted, cut short or plain noise
   task automatic rand_frame();
      logic [7:0]  proto;
      logic [7:0]  b;
      logic [31:0] len;
      logic [31:0] flip;
      logic [31:0] acc;
      logic        first_rst;
      longint      cut;
      longint      total;
      longint      i;
      int          pick;
      int          k;
      int          n;
      first_rst = resync || ($urandom_range(0, 3) == 0);
      resync    = 1'b0;
      pick      = $urandom_range(0, 99);
      // noise: random words with stray restarts, then resync
      if (pick >= 93) begin
         n = $urandom_range(1, 12);
         repeat (n) send_word(8'($urandom), $urandom_range(0, 7) == 0);
         resync = 1'b1;
         return;
      end
      proto = $urandom_range(0, 1) ? fcc_pkg::PROTO_A : fcc_pkg::PROTO_B;
      k     = $urandom_range(0, 99);
      if (k < 55) begin
         len = $urandom_range(0, 8);
      end else if (k < 90) begin
         len = $urandom_range(9, 48);
      end else if (k < 95 && cur_limit <= 200) begin
         len = cur_limit;
      end else begin
         len = $urandom_range(49, 150);
      end
      if (len > cur_limit) len = cur_limit;
      flip = '0;
      cut  = -1;
      if (pick >= 60 && pick < 78) flip = $urandom | (32'd1 << $urandom_range(0, 31));
      if (pick >= 70 && pick < 78) begin
         do proto = 8'($urandom);
         while (proto == fcc_pkg::PROTO_A || proto == fcc_pkg::PROTO_B);
         if ($urandom_range(0, 1)) flip = '0;
      end
      if (pick >= 78 && pick < 86 && cur_limit != 32'hFFFF_FFFF) begin
         // over-long header only; any protocol byte
         len = $urandom;
         if (len <= cur_limit) len = cur_limit + 1;
         if ($urandom_range(0, 1)) proto = 8'($urandom);
         cut = 1 + LEN_FIELD;
      end
      total = 1 + LEN_FIELD + longint'(len) + fcc_pkg::CRC_FIELD_BYTES;
      if (pick >= 86) begin
         cut    = $urandom_range(1, int'(total) - 1);
         resync = 1'b1;
      end
      acc = fcc_pkg::CRC_INIT;
      for (i = 0; i < total && (cut < 0 || i < cut); i++) begin
         if (i == 0) begin
            b = proto;
         end else if (i <= LEN_FIELD) begin
            b = len[8 * (LEN_FIELD - i) +: 8];
         end else if (i < 1 + LEN_FIELD + len) begin
            b = 8'($urandom);
         end else begin
            k = int'(i - 1 - LEN_FIELD - len);
            b = 8'((acc ^ flip) >> (8 * (3 - k)));
         end
         if (i < 1 + LEN_FIELD + len) acc = crc_next(acc, b);
         send_word(b, (i == 0) ? first_rst : 1'b0);
      end
   endtask

   initial begin
      int          r;
      int          p;
      logic [31:0] acc;
      logic [7:0]  b;
      logic [31:0] limits [0:5];
      // phase 0 runs on the reset limit; phase 2 runs without any idling
      limits    = '{32'd4096, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd4096};
      limits[4] = $urandom_range(2, 64);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the script, building good CRC bytes where a row asks for them
      acc = fcc_pkg::CRC_INIT;
      for (r = 0; r < SCRIPT_ROWS; r++) begin
         if (script[r].opens) acc = fcc_pkg::CRC_INIT;
         if (script[r].crc_byte) begin
            b = 8'(acc >> (8 * (3 - script[r].value[1:0])));
         end else begin
            b   = script[r].value;
            acc = crc_next(acc, b);
         end
         pin_on     <= script[r].pinned;
         pin_status <= script[r].status;
         pin_length <= script[r].length;
         send_word(b, script[r].restart);
      end
      pin_on <= 1'b0;

      for (p = 0; p < 6; p++) begin
         if (p > 0) begin
            settle();
            write_limit(limits[p]);
         end
         idling = (p != 2);
         while (words_sent < PHASE_WORDS * (p + 1) + SCRIPT_ROWS) rand_frame();
      end
      settle();

      if (faults == 0 && awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("timed out with %0d status words outstanding", awaited.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
